### src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared widths, reset values, register indexes and types of the IR distance
// frame block.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int ADC_W      = 12;
    localparam int DIST_W     = 12;
    localparam int IDX_W      = 6;
    localparam int NUM_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int FRAME_LEN_DEF = 64;

    localparam logic [ADC_W-1:0]  NEAR_CUTOFF_RST     = 12'd494;
    localparam logic [ADC_W-1:0]  SAMPLE_OFFSET_RST   = 12'd159;
    localparam logic [NUM_W-1:0]  RANGE_NUMERATOR_RST = 20'd268130;
    localparam logic [DIST_W-1:0] FAR_DISTANCE_RST    = 12'd799;
    localparam logic [DIST_W-1:0] DIST_MAX            = 12'hFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_CUTOFF,
        CFG_SAMPLE_OFFSET,
        CFG_RANGE_NUMERATOR,
        CFG_FAR_DISTANCE
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/mfd_window.sv
// ----------------------------------------------------------------------------
// mfd_window
// Three-tap sample window with a registered median of the new sample and the
// two stored taps.
// ----------------------------------------------------------------------------
module mfd_window
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift_en,
    input  logic [mfd_pkg::ADC_W-1:0] sample,
    output logic [mfd_pkg::ADC_W-1:0] median
);
    import mfd_pkg::*;

    logic [ADC_W-1:0] newer_reg;
    logic [ADC_W-1:0] older_reg;
    logic [ADC_W-1:0] median_reg;
    logic [ADC_W-1:0] median_next;
    logic [ADC_W-1:0] lo_ab;
    logic [ADC_W-1:0] hi_ab;
    logic [ADC_W-1:0] lo_hc;

    always_comb
    begin
        lo_ab       = (sample < newer_reg) ? sample : newer_reg;
        hi_ab       = (sample > newer_reg) ? sample : newer_reg;
        lo_hc       = (hi_ab < older_reg) ? hi_ab : older_reg;
        median_next = (lo_ab > lo_hc) ? lo_ab : lo_hc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newer_reg <= '0;
            older_reg <= '0;
        end
        else if (shift_en)
        begin
            newer_reg <= sample;
            older_reg <= newer_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

### src/mfd_serdiv.sv
// ----------------------------------------------------------------------------
// mfd_serdiv
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out MSB first while quotient bits shift in.
// ----------------------------------------------------------------------------
module mfd_serdiv
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mfd_pkg::NUM_W-1:0]  dividend,
    input  logic [mfd_pkg::ADC_W-1:0]  divisor,
    output mfd_pkg::div_stat_t         stat,
    output logic [mfd_pkg::NUM_W-1:0]  quotient
);
    import mfd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [ADC_W-1:0] rem_reg;
    logic [ADC_W-1:0] div_reg;

    logic [ADC_W:0]   trial;
    logic [ADC_W:0]   diff;
    logic             ge;
    logic [ADC_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[ADC_W-1:0] : trial[ADC_W-1:0];
        num_next = {num_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

### src/median3_ir_distance_frame.sv
// ----------------------------------------------------------------------------
// median3_ir_distance_frame
// IR range front end: median of three samples, reciprocal conversion to mm,
// 64-sample frames with rearm.
// ----------------------------------------------------------------------------
// One item at a time. A sample transaction that converts through the divider
// goes from acceptance through registering the median, picking the path, the
// bit-serial divider steps (one quotient bit per cycle, one step per dividend
// bit), completion and loading the output register before the block is ready
// again. Medians below near_cutoff or not above sample_offset skip the
// divider and go from picking the path straight to loading the output
// register. Rearm transactions and samples past the end of a frame are
// consumed in the idle state. A result waiting in the output register does
// not block acceptance; only loading the next result waits for it to be taken.
// ----------------------------------------------------------------------------
module median3_ir_distance_frame
#(
    parameter int FRAME_LEN = mfd_pkg::FRAME_LEN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [11:0] adc_sample
    input  logic [0:0]                          s_axis_tuser,  // [0] mode
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // [11:0] distance_mm,
                                                               // [17:12] sample_index
    output logic                                m_axis_tlast   // frame_last
);
    import mfd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIV,
        ST_OUT
    } state_t;

    // configuration registers
    logic [ADC_W-1:0]  near_cutoff_reg;
    logic [ADC_W-1:0]  sample_offset_reg;
    logic [NUM_W-1:0]  range_numerator_reg;
    logic [DIST_W-1:0] far_distance_reg;

    state_t            state_reg;
    logic [CNT_W-1:0]  frame_count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_reg;
    logic [DIST_W-1:0] result_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    logic              accept;
    logic              mode;
    logic              frame_full;
    logic [ADC_W-1:0]  median;
    logic              below_cutoff;
    logic              no_divisor;
    logic              div_start;
    logic [ADC_W-1:0]  divisor;
    div_stat_t         div_stat;
    logic [NUM_W-1:0]  quotient;
    logic [DIST_W-1:0] quot_sat;
    logic              out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_cutoff_reg     <= NEAR_CUTOFF_RST;
            sample_offset_reg   <= SAMPLE_OFFSET_RST;
            range_numerator_reg <= RANGE_NUMERATOR_RST;
            far_distance_reg    <= FAR_DISTANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NEAR_CUTOFF:     near_cutoff_reg     <= cfg_data[ADC_W-1:0];
                CFG_SAMPLE_OFFSET:   sample_offset_reg   <= cfg_data[ADC_W-1:0];
                CFG_RANGE_NUMERATOR: range_numerator_reg <= cfg_data[NUM_W-1:0];
                CFG_FAR_DISTANCE:    far_distance_reg    <= cfg_data[DIST_W-1:0];
                default:             ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = s_axis_tuser[0];
    assign frame_full    = (frame_count_reg >= FULL_CNT);

    mfd_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept && !mode),
        .sample   (s_axis_tdata[ADC_W-1:0]),
        .median   (median)
    );

    assign below_cutoff = (median < near_cutoff_reg);
    assign no_divisor   = (median <= sample_offset_reg);
    assign divisor      = median - sample_offset_reg;
    assign div_start    = (state_reg == ST_CONV) && !below_cutoff && !no_divisor;

    mfd_serdiv u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (range_numerator_reg),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign quot_sat = (|quotient[NUM_W-1:DIST_W]) ? DIST_MAX : quotient[DIST_W-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode)
                        begin
                            frame_count_reg <= '0;
                        end
                        else if (!frame_full)
                        begin
                            idx_reg         <= IDX_W'(frame_count_reg);
                            last_reg        <= (frame_count_reg == LAST_CNT);
                            frame_count_reg <= frame_count_reg + 1'b1;
                            state_reg       <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    if (below_cutoff)
                    begin
                        result_reg <= far_distance_reg;
                        state_reg  <= ST_OUT;
                    end
                    else if (no_divisor)
                    begin
                        result_reg <= DIST_MAX;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        result_reg <= quot_sat;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dist_reg  <= result_reg;
                        out_idx_reg   <= idx_reg;
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_idx_reg, out_dist_reg};
    assign m_axis_tlast  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= FULL_CNT)
        else $error("frame count past frame length");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[17:12] == LAST_IDX)
        else $error("tlast on wrong sample index");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_stat.busy && !div_stat.done)
        else $error("input accepted while divider active");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider result with no conversion pending");

endmodule
